### rtl/core/rfc_pkg.sv
package rfc_pkg;

    localparam int CANVAS_SIZE = 128;
    localparam int DEPTH       = CANVAS_SIZE * CANVAS_SIZE;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Wide enough for a column plus a span and for the canvas size itself.
    localparam int COORD_W     = $clog2(CANVAS_SIZE + 256) + 1;

    localparam logic [ADDR_W-1:0]  CS_A      = ADDR_W'(CANVAS_SIZE);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [COORD_W-1:0] CS_C      = COORD_W'(CANVAS_SIZE);
    localparam logic [23:0]        WHITE     = 24'hFFFFFF;
    localparam logic [7:0]         SAT_MAX   = 8'd255;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       en;
        logic [6:0] col;
        logic [6:0] row;
        logic [7:0] span_x;
        logic [7:0] span_y;
    } ext_upd_t;

endpackage

### rtl/core/rfc_extent.sv
module rfc_extent (
    input  logic              clk,
    input  logic              rst_n,
    input  rfc_pkg::ext_upd_t upd,
    output logic [7:0]        used_width,
    output logic [7:0]        used_height
);
    import rfc_pkg::*;

    logic [7:0] width_reg;
    logic [7:0] width_next;
    logic [7:0] height_reg;
    logic [7:0] height_next;
    logic [8:0] right_sum;
    logic [8:0] bottom_sum;
    logic [7:0] right_sat;
    logic [7:0] bottom_sat;

    always_comb
    begin
        right_sum   = {2'b00, upd.col} + {1'b0, upd.span_x};
        bottom_sum  = {2'b00, upd.row} + {1'b0, upd.span_y};
        right_sat   = right_sum[8] ? SAT_MAX : right_sum[7:0];
        bottom_sat  = bottom_sum[8] ? SAT_MAX : bottom_sum[7:0];
        width_next  = width_reg;
        height_next = height_reg;
        if (upd.en)
        begin
            if (right_sat > width_reg)
            begin
                width_next = right_sat;
            end
            if (bottom_sat > height_reg)
            begin
                height_next = bottom_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign used_width  = width_reg;
    assign used_height = height_reg;

endmodule

### rtl/core/rectangle_fill_canvas.sv
// Rectangle fill canvas: a 128 x 128 RGB pixel store with a fill sequencer.
// Requests arrive on the in_valid/in_ready channel. A draw request paints a
// clipped rectangle one pixel per cycle through the single memory write
// port; a read request fetches one pixel through the registered read port.
// Each request produces one result on out_valid/out_ready, carrying the
// pixel colour (zero after a draw or a read off the canvas) and the used
// extent after that request.
// A draw walks the clipped rectangle row by row through the memory write
// port, or goes straight to ST_DONE if nothing is painted; a read passes
// through ST_READ to ST_DONE. ST_DONE waits while a result is pending. One
// request is in work at a time, and in_ready rises together with out_valid.
// After reset the block sweeps all 16384 pixels of the store to white, one
// pixel a cycle, with in_ready low; the extent resets to zero.
// The result sits in an output register: a new request may be accepted
// while it waits, but the next result is held back until out_ready takes
// the pending one.
module rectangle_fill_canvas (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [6:0] left,
    input  logic [6:0] top,
    input  logic [7:0] span_x,
    input  logic [7:0] span_y,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] pixel_red,
    output logic [7:0] pixel_green,
    output logic [7:0] pixel_blue,
    output logic [7:0] used_width,
    output logic [7:0] used_height
);
    import rfc_pkg::*;

    logic [23:0] mem [DEPTH];
    logic [23:0] rd_data_reg;

    state_t               state_reg;
    state_t               state_next;
    logic [COORD_W-1:0]   x_reg;
    logic [COORD_W-1:0]   x_next;
    logic [COORD_W-1:0]   y_reg;
    logic [COORD_W-1:0]   y_next;
    logic [COORD_W-1:0]   x_start_reg;
    logic [COORD_W-1:0]   x_start_next;
    logic [COORD_W-1:0]   x_end_reg;
    logic [COORD_W-1:0]   x_end_next;
    logic [COORD_W-1:0]   y_end_reg;
    logic [COORD_W-1:0]   y_end_next;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    addr_next;
    logic [ADDR_W-1:0]    line_reg;
    logic [ADDR_W-1:0]    line_next;
    logic [23:0]          colour_reg;
    logic [23:0]          colour_next;
    logic                 op_reg;
    logic                 op_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           red_reg;
    logic [7:0]           red_next;
    logic [7:0]           green_reg;
    logic [7:0]           green_next;
    logic [7:0]           blue_reg;
    logic [7:0]           blue_next;
    logic [7:0]           uw_reg;
    logic [7:0]           uw_next;
    logic [7:0]           uh_reg;
    logic [7:0]           uh_next;

    logic                 accept;
    logic                 wr_en;
    logic [23:0]          wr_data;
    logic [COORD_W-1:0]   col_c;
    logic [COORD_W-1:0]   row_c;
    logic [COORD_W-1:0]   x_sum;
    logic [COORD_W-1:0]   y_sum;
    logic                 in_canvas;
    logic [ADDR_W-1:0]    row_base;
    logic [ADDR_W-1:0]    line_step;
    logic                 load_out;
    logic [7:0]           ext_w;
    logic [7:0]           ext_h;
    ext_upd_t             ext_upd;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign col_c     = COORD_W'(left);
    assign row_c     = COORD_W'(top);
    assign x_sum     = col_c + COORD_W'(span_x);
    assign y_sum     = row_c + COORD_W'(span_y);
    assign in_canvas = (col_c < CS_C) && (row_c < CS_C);
    assign row_base  = ADDR_W'(top) * CS_A;
    assign line_step = line_reg + CS_A;

    assign ext_upd.en     = accept && (operation == OP_DRAW);
    assign ext_upd.col    = left;
    assign ext_upd.row    = top;
    assign ext_upd.span_x = span_x;
    assign ext_upd.span_y = span_y;

    rfc_extent u_extent (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (ext_upd),
        .used_width  (ext_w),
        .used_height (ext_h)
    );

    assign wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_FILL);
    assign wr_data = (state_reg == ST_CLEAR) ? WHITE : colour_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        x_start_next   = x_start_reg;
        x_end_next     = x_end_reg;
        y_end_next     = y_end_reg;
        addr_next      = addr_reg;
        line_next      = line_reg;
        colour_next    = colour_reg;
        op_next        = op_reg;
        hit_next       = hit_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        uw_next        = uw_reg;
        uh_next        = uh_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = operation;
                    hit_next     = in_canvas;
                    colour_next  = {red, green, blue};
                    x_next       = col_c;
                    y_next       = row_c;
                    x_start_next = col_c;
                    x_end_next   = (x_sum > CS_C) ? CS_C : x_sum;
                    y_end_next   = (y_sum > CS_C) ? CS_C : y_sum;
                    line_next    = row_base;
                    addr_next    = row_base + ADDR_W'(left);
                    if (operation == OP_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (in_canvas && (span_x != 8'd0) && (span_y != 8'd0))
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FILL:
            begin
                if (x_reg + 1'b1 == x_end_reg)
                begin
                    if (y_reg + 1'b1 == y_end_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        y_next    = y_reg + 1'b1;
                        x_next    = x_start_reg;
                        line_next = line_step;
                        addr_next = line_step + ADDR_W'(x_start_reg);
                    end
                end
                else
                begin
                    x_next    = x_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                // The registered read port holds the pixel from the next cycle.
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
            uw_next        = ext_w;
            uh_next        = ext_h;
            if ((op_reg == OP_READ) && hit_reg)
            begin
                red_next   = rd_data_reg[23:16];
                green_next = rd_data_reg[15:8];
                blue_next  = rd_data_reg[7:0];
            end
            else
            begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        x_start_reg <= x_start_next;
        x_end_reg   <= x_end_next;
        y_end_reg   <= y_end_next;
        line_reg    <= line_next;
        colour_reg  <= colour_next;
        op_reg      <= op_next;
        hit_reg     <= hit_next;
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
        uw_reg      <= uw_next;
        uh_reg      <= uh_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_red   = red_reg;
    assign pixel_green = green_reg;
    assign pixel_blue  = blue_reg;
    assign used_width  = uw_reg;
    assign used_height = uh_reg;

endmodule

### test/tb_rectangle_fill_canvas.sv
`timescale 1ns / 1ps

module tb_rectangle_fill_canvas;

    import rfc_pkg::*;

    localparam int     CLK_PERIOD     = 4;
    localparam int     RESET_CYCLES   = 7;
    localparam longint TIMEOUT_CYCLES = 4_000_000;
    localparam int     RANDOM_ITEMS   = 450;
    localparam int     CHUNK_ITEMS    = 50;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] width;
        logic [7:0] height;
    } canvas_reply_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       operation;
    logic [6:0] left;
    logic [6:0] top;
    logic [7:0] span_x;
    logic [7:0] span_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] used_width;
    logic [7:0] used_height;

    // Mirror of the canvas and its extent, updated as each request is accepted.
    logic [23:0]   canvas_model [0:DEPTH-1];
    logic [7:0]    extent_w_model;
    logic [7:0]    extent_h_model;
    canvas_reply_t pending_replies [$];

    int mismatch_count;
    int hold_off_request;
    bit sender_idle;
    bit receiver_idle;

    // Clipped bounds of the most recent rectangle, so that reads can land on it.
    int last_x0;
    int last_x1;
    int last_y0;
    int last_y1;

    rectangle_fill_canvas DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .left        (left),
        .top         (top),
        .span_x      (span_x),
        .span_y      (span_y),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .used_width  (used_width),
        .used_height (used_height)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic canvas_reply_t paint_and_sample(
        input logic       op,
        input logic [6:0] x,
        input logic [6:0] y,
        input logic [7:0] sx,
        input logic [7:0] sy,
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b
    );
        canvas_reply_t rep;
        logic [8:0]    right;
        logic [8:0]    bottom;
        int            x_end;
        int            y_end;
        int            xx;
        int            yy;
        rep = '0;
        if (op == OP_DRAW)
        begin
            right  = {2'b00, x} + {1'b0, sx};
            bottom = {2'b00, y} + {1'b0, sy};
            x_end  = int'(x) + int'(sx);
            y_end  = int'(y) + int'(sy);
            if (x_end > CANVAS_SIZE)
                x_end = CANVAS_SIZE;
            if (y_end > CANVAS_SIZE)
                y_end = CANVAS_SIZE;
            for (yy = int'(y); yy < y_end; yy++)
                for (xx = int'(x); xx < x_end; xx++)
                    canvas_model[yy * CANVAS_SIZE + xx] = {r, g, b};
            if (right > 9'(SAT_MAX))
                right = 9'(SAT_MAX);
            if (bottom > 9'(SAT_MAX))
                bottom = 9'(SAT_MAX);
            if (right[7:0] > extent_w_model)
                extent_w_model = right[7:0];
            if (bottom[7:0] > extent_h_model)
                extent_h_model = bottom[7:0];
        end
        else
        begin
            {rep.red, rep.green, rep.blue} = canvas_model[int'(y) * CANVAS_SIZE + int'(x)];
        end
        rep.width  = extent_w_model;
        rep.height = extent_h_model;
        return rep;
    endfunction

    // Offers one request and returns at the clock edge that accepts it.
    task automatic send_request(
        input logic       op,
        input logic [6:0] x,
        input logic [6:0] y,
        input logic [7:0] sx,
        input logic [7:0] sy,
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b
    );
        int gap;
        gap = sender_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        left      <= x;
        top       <= y;
        span_x    <= sx;
        span_y    <= sy;
        red       <= r;
        green     <= g;
        blue      <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_replies.push_back(paint_and_sample(op, x, y, sx, sy, r, g, b));
    endtask

    task automatic send_draw(
        input int x,
        input int y,
        input int sx,
        input int sy,
        input int r,
        input int g,
        input int b
    );
        last_x0 = x;
        last_y0 = y;
        last_x1 = (x + sx > CANVAS_SIZE) ? CANVAS_SIZE : x + sx;
        last_y1 = (y + sy > CANVAS_SIZE) ? CANVAS_SIZE : y + sy;
        send_request(OP_DRAW, 7'(x), 7'(y), 8'(sx), 8'(sy), 8'(r), 8'(g), 8'(b));
    endtask

    // The span and colour fields carry junk on a read, since the block ignores them.
    task automatic send_read(input int x, input int y);
        send_request(OP_READ, 7'(x), 7'(y), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_replies_drained();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiving side: random stalls, plus a long hold-off when a test asks for one.
    initial
    begin
        int            stall;
        canvas_reply_t want;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = receiver_idle ? $urandom_range(0, 7) : 0;
            stall += hold_off_request;
            hold_off_request = 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_replies.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("pixel_red", want.red, pixel_red);
                check_field("pixel_green", want.green, pixel_green);
                check_field("pixel_blue", want.blue, pixel_blue);
                check_field("used_width", want.width, used_width);
                check_field("used_height", want.height, used_height);
            end
        end
    end

    task automatic test_cleared_canvas();
        send_read(0, 0);
        send_read(127, 127);
        send_read(64, 31);
        wait_replies_drained();
    endtask

    // A zero span paints nothing but still widens the extent.
    task automatic test_empty_rectangles();
        send_draw(10, 20, 0, 5, 1, 2, 3);
        send_read(10, 20);
        send_draw(30, 2, 3, 0, 4, 5, 6);
        send_read(30, 2);
        wait_replies_drained();
    endtask

    task automatic test_clipping();
        send_draw(120, 124, 16, 8, 8'h12, 8'h34, 8'h56);
        send_read(127, 127);
        send_read(119, 124);
        send_read(127, 123);
        send_draw(0, 126, 128, 2, 8'hA5, 8'h5A, 8'hC3);
        wait_replies_drained();
    endtask

    task automatic test_overlap();
        send_draw(4, 4, 10, 10, 255, 0, 0);
        send_draw(8, 8, 10, 10, 0, 255, 0);
        send_read(5, 5);
        send_read(9, 9);
        send_read(17, 17);
        send_read(3, 3);
        wait_replies_drained();
    endtask

    task automatic test_full_canvas();
        send_draw(0, 0, 128, 128, 0, 0, 0);
        send_read(127, 0);
        send_draw(0, 0, 128, 128, 255, 255, 255);
        send_read(0, 127);
        wait_replies_drained();
    endtask

    // The receiver holds off while requests keep coming, so the input stalls.
    task automatic test_output_backpressure();
        int  i;
        bit  saved_idle;
        saved_idle       = sender_idle;
        sender_idle      = 1'b0;
        hold_off_request = 300;
        for (i = 0; i < 12; i++)
        begin
            if (i % 3 == 0)
                send_draw($urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 3), $urandom_range(0, 3),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            else
                send_read($urandom_range(0, 127), $urandom_range(0, 127));
        end
        wait_replies_drained();
        sender_idle = saved_idle;
    endtask

    task automatic test_random_traffic();
        int i;
        int shape;
        int sx;
        int sy;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // The first stretch runs flat out on both sides.
            if (i % CHUNK_ITEMS == 0)
            begin
                sender_idle   = (i == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
                receiver_idle = (i == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 9) < 4)
            begin
                if (last_x1 > last_x0 && last_y1 > last_y0 && $urandom_range(0, 9) < 6)
                    send_read($urandom_range(last_x0, last_x1 - 1),
                              $urandom_range(last_y0, last_y1 - 1));
                else
                    send_read($urandom_range(0, 127), $urandom_range(0, 127));
            end
            else
            begin
                shape = $urandom_range(0, 9);
                if (shape < 7)
                begin
                    sx = $urandom_range(0, 12);
                    sy = $urandom_range(0, 12);
                end
                else if (shape < 9)
                begin
                    // Thin strips reach the far span values and run off the edge.
                    if ($urandom_range(0, 1) == 1)
                    begin
                        sx = $urandom_range(0, 255);
                        sy = $urandom_range(0, 3);
                    end
                    else
                    begin
                        sx = $urandom_range(0, 3);
                        sy = $urandom_range(0, 255);
                    end
                end
                else
                begin
                    sx = $urandom_range(0, 40);
                    sy = $urandom_range(0, 40);
                end
                send_draw($urandom_range(0, 127), $urandom_range(0, 127), sx, sy,
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            end
        end
        wait_replies_drained();
    endtask

    // Left plus span passes 255 here, so the extent saturates.
    task automatic test_extent_saturation();
        send_draw(127, 127, 255, 255, 8'h0F, 8'hF0, 8'h81);
        send_read(127, 127);
        send_read(126, 126);
        wait_replies_drained();
    endtask

    initial
    begin
        int i;
        for (i = 0; i < DEPTH; i++)
            canvas_model[i] = WHITE;
        extent_w_model   = '0;
        extent_h_model   = '0;
        mismatch_count   = 0;
        hold_off_request = 0;
        sender_idle      = 1'b1;
        receiver_idle    = 1'b1;
        last_x0          = 0;
        last_x1          = 0;
        last_y0          = 0;
        last_y1          = 0;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        operation <= OP_DRAW;
        left      <= '0;
        top       <= '0;
        span_x    <= '0;
        span_y    <= '0;
        red       <= '0;
        green     <= '0;
        blue      <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_cleared_canvas();
        test_empty_rectangles();
        test_clipping();
        test_overlap();
        test_full_canvas();
        test_output_backpressure();
        test_random_traffic();
        test_extent_saturation();

        repeat (32) @(posedge clk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
